// ----- rtl/core/dlfb_pkg.sv -----
// ----------------------------------------------------------------------------
// dlfb_pkg
// Shared types and constants of the dense layer forward/backward unit.
// ----------------------------------------------------------------------------
`default_nettype none
package dlfb_pkg;

  localparam int FUNC_W  = 3;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 5;
  localparam int DATA_W  = 16;
  localparam int RES_W   = 40;
  localparam int CNT_W   = 5;
  localparam int LAMBDA_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_WR_WEIGHT = 3'd0,
    FN_WR_INPUT  = 3'd1,
    FN_WR_DELTA  = 3'd2,
    FN_FORWARD   = 3'd3,
    FN_BACKWARD  = 3'd4,
    FN_GRADIENT  = 3'd5
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_COUNT  = 2'd0,
    CFG_INPUT_COUNT = 2'd1,
    CFG_REG_LAMBDA  = 2'd2
  } cfg_reg_t;

  localparam logic signed [DATA_W-1:0] ONE_Q88 = 16'sd256;

endpackage
`default_nettype wire

// ----- rtl/core/dlfb_if.sv -----
// ----------------------------------------------------------------------------
// dlfb channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface dlfb_in_if import dlfb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [ROW_W-1:0]         row_index;
  logic [COL_W-1:0]         col_index;
  logic signed [DATA_W-1:0] data_value;
  modport source (output valid, func, row_index, col_index, data_value, input ready);
  modport sink   (input valid, func, row_index, col_index, data_value, output ready);
endinterface

interface dlfb_out_if import dlfb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic [COL_W-1:0]        result_index;
  logic                    last;
  modport source (output valid, result_value, result_index, last, input ready);
  modport sink   (input valid, result_value, result_index, last, output ready);
endinterface

interface dlfb_cfg_if import dlfb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/dlfb_ram.sv -----
// ----------------------------------------------------------------------------
// dlfb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module dlfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/dense_layer_forward_backward_unit.sv -----
// ----------------------------------------------------------------------------
// dense_layer_forward_backward_unit
// Fully connected layer: forward, backward delta and L2 weight gradient.
// ----------------------------------------------------------------------------
// Requests arrive on in_*: write weight / input / delta, forward, backward or
// gradient row. Writes return nothing and leave in_ready high. Compute
// requests stream results on out_*, one element per run step with last on
// the final one. Weights, inputs and deltas live in three registered-read
// RAMs; one shared multiply-accumulate walks them, one product (for gradient,
// a sum of two) per cycle unless stalled, with a registered read ahead of it
// and one product register after. Writes, unknown codes and out-of-range
// gradient rows leave the unit idle. One request is in work at a time;
// in_ready is low until its last result has been taken. A result waits in
// the output register while out_ready is low; the walk pauses only when the
// next result is due. Reset (rst_n low, synchronous) restores both counts to
// 16 and lambda to zero; store contents are undefined until written. Register
// writes on cfg_* are always taken.
// ----------------------------------------------------------------------------
`default_nettype none
module dense_layer_forward_backward_unit import dlfb_pkg::*; #(
  parameter int MAX_UNITS  = 16,
  parameter int MAX_INPUTS = 16
) (
  input wire logic    clk,
  input wire logic    rst_n,
  dlfb_in_if.sink     in_ch,
  dlfb_out_if.source  out_ch,
  dlfb_cfg_if.sink    cfg_ch
);
  localparam int COLS  = MAX_INPUTS + 1;
  localparam int WDEP  = MAX_UNITS * COLS;
  localparam int WA_W  = $clog2(WDEP);
  localparam int UA_W  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int IA_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int UC_W  = $clog2(MAX_UNITS + 1);
  localparam int IC_W  = $clog2(MAX_INPUTS + 2);
  localparam int IDX_W = (UC_W > IC_W) ? UC_W : IC_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

  // config
  logic [CNT_W-1:0]    unit_count_r, input_count_r;
  logic [LAMBDA_W-1:0] lambda_r;
  logic [UC_W-1:0]     nu;
  logic [IC_W-1:0]     ni;

  always_comb begin
    if (unit_count_r == '0) nu = UC_W'(1);
    else if (32'(unit_count_r) > MAX_UNITS) nu = UC_W'(MAX_UNITS);
    else nu = UC_W'(unit_count_r);
    if (input_count_r == '0) ni = IC_W'(1);
    else if (32'(input_count_r) > MAX_INPUTS) ni = IC_W'(MAX_INPUTS);
    else ni = IC_W'(input_count_r);
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_count_r  <= CNT_W'(16);
      input_count_r <= CNT_W'(16);
      lambda_r      <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_UNIT_COUNT:  unit_count_r  <= cfg_ch.data[CNT_W-1:0];
        CFG_INPUT_COUNT: input_count_r <= cfg_ch.data[CNT_W-1:0];
        CFG_REG_LAMBDA:  lambda_r      <= cfg_ch.data[LAMBDA_W-1:0];
        default: ;
      endcase
    end
  end

  // memories
  logic              w_we, x_we, d_we;
  logic [WA_W-1:0]   w_waddr, w_raddr, w_ra_walk, w_raddr_r;
  logic [IA_W-1:0]   x_waddr, x_raddr, x_ra_walk, x_raddr_r;
  logic [UA_W-1:0]   d_waddr, d_raddr, d_ra_walk, d_raddr_r;
  logic [DATA_W-1:0] w_rdata, x_rdata, d_rdata;

  dlfb_ram #(.WIDTH(DATA_W), .DEPTH(WDEP)) u_wram (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(in_ch.data_value),
    .raddr(w_raddr), .rdata(w_rdata));
  dlfb_ram #(.WIDTH(DATA_W), .DEPTH(MAX_INPUTS)) u_xram (
    .clk, .we(x_we), .waddr(x_waddr), .wdata(in_ch.data_value),
    .raddr(x_raddr), .rdata(x_rdata));
  dlfb_ram #(.WIDTH(DATA_W), .DEPTH(MAX_UNITS)) u_dram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(in_ch.data_value),
    .raddr(d_raddr), .rdata(d_rdata));

  // walk state
  state_t            state_r;
  func_t             func_r;
  logic [UA_W-1:0]   grow_r;
  logic [IDX_W-1:0]  outer_r;   // row (fwd), input (bwd)
  logic [IDX_W-1:0]  inner_r;   // column (fwd/grad), row (bwd)
  logic              s1_v_r, s1_first_r, s1_end_r, s1_last_r, s1_bias_r;
  logic [COL_W-1:0]  s1_idx_r;
  logic              s2_v_r, s2_first_r, s2_end_r, s2_last_r;
  logic [COL_W-1:0]  s2_idx_r;
  logic signed [2*DATA_W+1:0] p2_r;
  logic signed [RES_W-1:0]   acc_r;
  logic              ov_r, olast_r;
  logic signed [RES_W-1:0] oval_r;
  logic [COL_W-1:0]  oidx_r;
  logic              issue_done_r;

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // write path
  always_comb begin
    w_we = accept && func_t'(in_ch.func) == FN_WR_WEIGHT
           && 32'(in_ch.row_index) < MAX_UNITS && 32'(in_ch.col_index) < COLS;
    x_we = accept && func_t'(in_ch.func) == FN_WR_INPUT
           && 32'(in_ch.col_index) < MAX_INPUTS;
    d_we = accept && func_t'(in_ch.func) == FN_WR_DELTA
           && 32'(in_ch.row_index) < MAX_UNITS;
    w_waddr = WA_W'(32'(in_ch.row_index) * COLS + 32'(in_ch.col_index));
    x_waddr = IA_W'(in_ch.col_index);
    d_waddr = UA_W'(in_ch.row_index);
  end

  // stall: the whole walk freezes when a finished sum cannot enter the output slot
  logic stall, go, load_out;
  assign stall    = ov_r && !out_ch.ready && s2_v_r && s2_end_r;
  assign go       = (state_r == S_RUN) && !issue_done_r && !stall;
  assign load_out = (state_r == S_RUN) && !stall && s2_v_r && s2_end_r;

  // address generation for current step
  logic [IDX_W-1:0] last_outer, last_inner;
  logic             is_first, is_end, is_last, is_bias;
  always_comb begin
    w_ra_walk = '0; x_ra_walk = '0; d_ra_walk = '0;
    is_bias = 1'b0;
    case (func_r)
      FN_FORWARD: begin
        last_outer = IDX_W'(nu - 1'b1);
        last_inner = IDX_W'(ni);
        w_ra_walk = WA_W'(32'(outer_r) * COLS + 32'(inner_r));
        x_ra_walk = IA_W'(inner_r - 1'b1);
        is_bias = (inner_r == '0);
      end
      FN_BACKWARD: begin
        last_outer = IDX_W'(ni - 1'b1);
        last_inner = IDX_W'(nu - 1'b1);
        w_ra_walk = WA_W'(32'(inner_r) * COLS + 32'(outer_r) + 1);
        d_ra_walk = UA_W'(inner_r);
      end
      default: begin // gradient: outer unused, inner is column
        last_outer = '0;
        last_inner = IDX_W'(ni);
        w_ra_walk = WA_W'(32'(grow_r) * COLS + 32'(inner_r));
        x_ra_walk = IA_W'(inner_r - 1'b1);
        d_ra_walk = grow_r;
        is_bias = (inner_r == '0);
      end
    endcase
    is_first = (inner_r == '0);
    is_end   = (func_r == FN_GRADIENT) ? 1'b1 : (inner_r == last_inner);
    is_last  = (func_r == FN_GRADIENT) ? (inner_r == last_inner)
                                       : (is_end && outer_r == last_outer);
  end

  // hold the stage 1 read while stalled so its data survives the pause
  assign w_raddr = stall ? w_raddr_r : w_ra_walk;
  assign x_raddr = stall ? x_raddr_r : x_ra_walk;
  assign d_raddr = stall ? d_raddr_r : d_ra_walk;

  always_ff @(posedge clk) begin
    w_raddr_r <= w_raddr;
    x_raddr_r <= x_raddr;
    d_raddr_r <= d_raddr;
  end

  // stage 2 product operands
  logic signed [DATA_W:0]  opa, opb;
  logic signed [DATA_W:0]  lam_s;
  assign lam_s = {1'b0, lambda_r};

  // gradient needs two products: delta*x and lambda*w
  logic signed [2*DATA_W:0] prod_a, prod_b;
  always_comb begin
    prod_b = '0;
    case (func_r)
      FN_FORWARD: begin
        opa = (DATA_W+1)'(signed'(w_rdata));
        opb = s1_bias_r ? (DATA_W+1)'(ONE_Q88) : (DATA_W+1)'(signed'(x_rdata));
      end
      FN_BACKWARD: begin
        opa = (DATA_W+1)'(signed'(w_rdata));
        opb = (DATA_W+1)'(signed'(d_rdata));
      end
      default: begin
        opa = (DATA_W+1)'(signed'(d_rdata));
        opb = s1_bias_r ? (DATA_W+1)'(ONE_Q88) : (DATA_W+1)'(signed'(x_rdata));
        prod_b = s1_bias_r ? '0
                           : (2*DATA_W+1)'(lam_s * (DATA_W+1)'(signed'(w_rdata)));
      end
    endcase
    prod_a = (2*DATA_W+1)'(opa * opb);
  end

  logic signed [RES_W-1:0] acc_sum;
  assign acc_sum = (s2_first_r ? RES_W'(0) : acc_r) + RES_W'(p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      ov_r <= 1'b0;
      issue_done_r <= 1'b0;
    end else begin
      if (load_out) ov_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r  <= func_t'(in_ch.func);
            grow_r  <= UA_W'(in_ch.row_index);
            outer_r <= '0;
            inner_r <= '0;
            issue_done_r <= 1'b0;
            if (func_t'(in_ch.func) == FN_FORWARD || func_t'(in_ch.func) == FN_BACKWARD
                || (func_t'(in_ch.func) == FN_GRADIENT && UC_W'(in_ch.row_index) < nu
                    && 32'(in_ch.row_index) < MAX_UNITS))
              state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (!stall) begin
            s1_v_r <= go;
            s1_first_r <= is_first || func_r == FN_GRADIENT;
            s1_end_r <= is_end;
            s1_last_r <= is_last;
            s1_bias_r <= is_bias;
            s1_idx_r <= (func_r == FN_GRADIENT) ? COL_W'(inner_r) : COL_W'(outer_r);
            if (go) begin
              if (is_last) issue_done_r <= 1'b1;
              else if (is_end && func_r != FN_GRADIENT) begin
                inner_r <= '0;
                outer_r <= outer_r + 1'b1;
              end else inner_r <= inner_r + 1'b1;
            end
            s2_v_r <= s1_v_r;
            s2_first_r <= s1_first_r;
            s2_end_r <= s1_end_r;
            s2_last_r <= s1_last_r;
            s2_idx_r <= s1_idx_r;
            p2_r <= (2*DATA_W+2)'(prod_a) + (2*DATA_W+2)'(prod_b);
            if (s2_v_r) begin
              acc_r <= acc_sum;
              if (s2_end_r) begin
                oval_r <= acc_sum;
                oidx_r <= s2_idx_r;
                olast_r <= s2_last_r;
                if (s2_last_r) state_r <= S_WAIT;
              end
            end
          end
        end
        S_WAIT: begin
          if (!ov_r || out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.result_value = oval_r;
  assign out_ch.result_index = oidx_r;
  assign out_ch.last         = olast_r;
endmodule
`default_nettype wire
